// ===== hdl/acl_pkg.sv =====
// acl_pkg: shared widths, codes and structs of the access-control-list checker
// no dependencies; used by the interfaces, the cell, the top level and the checker
package acl_pkg;

  localparam int ID_BITS   = 31;
  localparam int PERM_BITS = 8;
  localparam int IDX_BITS  = 4;
  localparam int CNT_BITS  = 5;
  localparam int ADDR_BITS = 3;

  localparam logic [ID_BITS-1:0]   ID_WILD    = {ID_BITS{1'b1}};
  localparam logic [ADDR_BITS-1:0] ADDR_COUNT = ADDR_BITS'(0);

  typedef enum logic [2:0] {
    OUT_SUPERUSER   = 3'd0,
    OUT_ALLOWED     = 3'd1,
    OUT_EMPTY       = 3'd2,
    OUT_DENIED      = 3'd3,
    OUT_NOT_COVERED = 3'd4,
    OUT_WRITTEN     = 3'd5
  } acl_outcome_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_CHECK = 1'b1
  } acl_kind_t;

  typedef struct packed {
    logic                 is_group;
    logic [ID_BITS-1:0]   id;
    logic                 deny;
    logic [PERM_BITS-1:0] mask;
  } acl_entry_t;

  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] index;
    acl_entry_t          entry;
  } acl_wr_t;

  // check request travelling down the row of cells
  typedef struct packed {
    logic                 valid;
    logic [ID_BITS-1:0]   uid;
    logic [ID_BITS-1:0]   gid;
    logic [PERM_BITS-1:0] req;
    logic                 deny_hit;
    logic [PERM_BITS-1:0] overlap;
    logic                 allow_hit;
  } acl_tok_t;

endpackage

// ===== hdl/acl_in_if.sv =====
// acl_in_if: request channel of the access-control-list checker
// depends on acl_pkg for field widths
interface acl_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [acl_pkg::IDX_BITS-1:0]   entry_index;
  logic                           entry_is_group;
  logic [acl_pkg::ID_BITS-1:0]    entry_id;
  logic                           entry_deny;
  logic [acl_pkg::PERM_BITS-1:0]  entry_perms;
  logic [acl_pkg::ID_BITS-1:0]    user_id;
  logic [acl_pkg::ID_BITS-1:0]    group_id;
  logic [acl_pkg::PERM_BITS-1:0]  requested_perms;

  modport source (
    output valid, kind, entry_index, entry_is_group, entry_id, entry_deny, entry_perms,
    output user_id, group_id, requested_perms,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_index, entry_is_group, entry_id, entry_deny, entry_perms,
    input  user_id, group_id, requested_perms,
    output ready
  );
endinterface

// ===== hdl/acl_out_if.sv =====
// acl_out_if: result channel of the access-control-list checker
// depends on acl_pkg for field widths
interface acl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           granted;
  logic [2:0]                     outcome;
  logic [acl_pkg::PERM_BITS-1:0]  offending_perms;

  modport source (output valid, granted, outcome, offending_perms, input ready);
  modport sink   (input valid, granted, outcome, offending_perms, output ready);
endinterface

// ===== hdl/acl_cell.sv =====
// acl_cell: one table entry plus one stage of the check pipeline
// depends on acl_pkg for the entry, write and request structs
module acl_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acl_pkg::acl_wr_t              wr,
  input  logic [acl_pkg::CNT_BITS-1:0]  count,
  input  acl_pkg::acl_tok_t             tok_i,
  output acl_pkg::acl_tok_t             tok_o
);

  acl_pkg::acl_entry_t            ent_r;
  acl_pkg::acl_tok_t              tok_r;
  acl_pkg::acl_tok_t              tok_nxt;
  logic                           consult;
  logic                           match;
  logic [acl_pkg::PERM_BITS-1:0]  hit_bits;

  always_comb begin
    consult  = INDEX < int'(count);
    match    = (ent_r.id == acl_pkg::ID_WILD) ||
               (ent_r.is_group ? (ent_r.id == tok_i.gid) : (ent_r.id == tok_i.uid));
    hit_bits = ent_r.mask & tok_i.req;
    tok_nxt  = tok_i;
    if (consult && match) begin
      if (ent_r.deny) begin
        if (!tok_i.deny_hit && (hit_bits != '0)) begin
          tok_nxt.deny_hit = 1'b1;
          tok_nxt.overlap  = hit_bits;
        end
      end else if (hit_bits == tok_i.req) begin
        tok_nxt.allow_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.index) == INDEX)) begin
      ent_r <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.uid       <= tok_nxt.uid;
    tok_r.gid       <= tok_nxt.gid;
    tok_r.req       <= tok_nxt.req;
    tok_r.deny_hit  <= tok_nxt.deny_hit;
    tok_r.overlap   <= tok_nxt.overlap;
    tok_r.allow_hit <= tok_nxt.allow_hit;
  end

  assign tok_o = tok_r;

endmodule

// ===== hdl/acl_permission_checker_top.sv =====
// acl_permission_checker_top: access-control-list permission checker
// depends on acl_pkg, acl_in_if, acl_out_if and acl_cell
//
// Usage
//   in_ch : valid/ready request channel. kind 0 loads entry entry_index of the
//           table, kind 1 checks user_id/group_id against requested_perms.
//   out_ch: valid/ready result channel, one result per request, in order.
//   APB   : register entries_in_use at byte address 0 (5 bits), written with
//           psel/penable/pwrite; pready is always high. Write it only while idle.
// Flow
//   Writes, superuser checks and checks against an empty table: the outcome is
//   set at acceptance and goes through ST_FIN into the output register.
//   Other checks walk a row of TABLE_DEPTH cells, one entry per cycle; the
//   outcome is taken from the last cell and goes through ST_FIN into the output
//   register. In both cases the controller then returns to ST_IDLE.
//   One request is in flight at a time; the output register holds a finished
//   result while the next request is accepted.
// Reset
//   Synchronous, active low: controller idle, output empty, count 0. Table
//   contents are not cleared and must be written before they are consulted.
// Stall
//   While out_ch.ready is low the result holds; a later result waits in the
//   controller and in_ch.ready stays low until it can move on.
module acl_permission_checker_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  acl_in_if.sink                         in_ch,
  acl_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [acl_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t                         state_r;
  logic [acl_pkg::CNT_BITS-1:0]   count_r;
  logic                           pend_granted_r;
  acl_pkg::acl_outcome_t          pend_outcome_r;
  logic [acl_pkg::PERM_BITS-1:0]  pend_offend_r;
  logic                           out_valid_r;
  logic                           out_granted_r;
  acl_pkg::acl_outcome_t          out_outcome_r;
  logic [acl_pkg::PERM_BITS-1:0]  out_offend_r;

  acl_pkg::acl_tok_t              tok [TABLE_DEPTH+1];
  acl_pkg::acl_wr_t               wr;
  logic                           in_fire;
  logic                           is_check;
  logic                           is_super;
  logic                           is_empty;
  logic                           out_free;
  acl_pkg::acl_tok_t              tail;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_check    = (in_ch.kind == acl_pkg::KIND_CHECK);
  assign is_super    = (in_ch.user_id == '0);
  assign is_empty    = (count_r == '0);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign tail        = tok[TABLE_DEPTH];

  always_comb begin
    wr.en                = in_fire && !is_check;
    wr.index             = in_ch.entry_index;
    wr.entry.is_group    = in_ch.entry_is_group;
    wr.entry.id          = in_ch.entry_id;
    wr.entry.deny        = in_ch.entry_deny;
    wr.entry.mask        = in_ch.entry_perms;
    tok[0].valid         = in_fire && is_check && !is_super && !is_empty;
    tok[0].uid           = in_ch.user_id;
    tok[0].gid           = in_ch.group_id;
    tok[0].req           = in_ch.requested_perms;
    tok[0].deny_hit      = 1'b0;
    tok[0].overlap       = '0;
    tok[0].allow_hit     = 1'b0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    acl_cell #(
      .INDEX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .wr    (wr),
      .count (count_r),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == acl_pkg::ADDR_COUNT) ? 32'(count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (psel && penable && pwrite && (paddr == acl_pkg::ADDR_COUNT)) begin
      count_r <= pwdata[acl_pkg::CNT_BITS-1:0];
    end
  end

  // controller and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            pend_offend_r <= '0;
            if (!is_check) begin
              pend_granted_r <= 1'b0;
              pend_outcome_r <= acl_pkg::OUT_WRITTEN;
              state_r        <= ST_FIN;
            end else if (is_super) begin
              pend_granted_r <= 1'b1;
              pend_outcome_r <= acl_pkg::OUT_SUPERUSER;
              state_r        <= ST_FIN;
            end else if (is_empty) begin
              pend_granted_r <= 1'b0;
              pend_outcome_r <= acl_pkg::OUT_EMPTY;
              state_r        <= ST_FIN;
            end else begin
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (tail.valid) begin
            state_r <= ST_FIN;
            priority if (tail.deny_hit) begin
              pend_granted_r <= 1'b0;
              pend_outcome_r <= acl_pkg::OUT_DENIED;
              pend_offend_r  <= tail.overlap;
            end else if (tail.allow_hit) begin
              pend_granted_r <= 1'b1;
              pend_outcome_r <= acl_pkg::OUT_ALLOWED;
              pend_offend_r  <= '0;
            end else begin
              pend_granted_r <= 1'b0;
              pend_outcome_r <= acl_pkg::OUT_NOT_COVERED;
              pend_offend_r  <= tail.req;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_granted_r <= pend_granted_r;
            out_outcome_r <= pend_outcome_r;
            out_offend_r  <= pend_offend_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.granted         = out_granted_r;
  assign out_ch.outcome         = out_outcome_r;
  assign out_ch.offending_perms = out_offend_r;

endmodule

// ===== hdl/acl_checker.sv =====
// acl_checker: port-level assertions for the access-control-list checker
// depends on acl_pkg; bound to acl_permission_checker_top
module acl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           granted,
  input logic [2:0]                     outcome,
  input logic [acl_pkg::PERM_BITS-1:0]  offending_perms
);

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(granted)
      && $stable(offending_perms))
    else $error("stalled result changed");

  // grant only with superuser or allowed outcome
  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && granted |-> outcome == acl_pkg::OUT_SUPERUSER
      || outcome == acl_pkg::OUT_ALLOWED)
    else $error("grant with a refusing outcome");

  // offending bits only on denial or missing cover
  a_offend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && offending_perms != '0 |-> outcome == acl_pkg::OUT_DENIED
      || outcome == acl_pkg::OUT_NOT_COVERED)
    else $error("offending bits with wrong outcome");

  // denial always names at least one bit
  a_deny_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && outcome == acl_pkg::OUT_DENIED |-> offending_perms != '0 && !granted)
    else $error("denial without overlap");

endmodule

bind acl_permission_checker_top acl_checker u_acl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .granted         (out_ch.granted),
  .outcome         (out_ch.outcome),
  .offending_perms (out_ch.offending_perms)
);
